/* hw/rtl/cte_pkg.sv */
// Shared types and constants for the capability table engine.
// Depends on nothing; every other file of the block but cte_ram imports it.
`default_nettype none

package cte_pkg;

    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 32;
    localparam int TYPE_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DERIVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REVOKE = 3'd4;

    localparam logic [CFG_W-1:0] REVOKE_MASK_RESET = 32'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_DENIED     = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_OBJECT = 3'd4
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/cte_if.sv */
// Request and response channel interfaces of the capability table engine.
// Depends on cte_pkg for the field widths.
`default_nettype none

interface cte_req_if;
    import cte_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [TYPE_W-1:0]   object_type;
    logic [FIELD_W-1:0]  object_id;
    logic [FIELD_W-1:0]  rights;

    modport source (output valid, kind, handle, object_type, object_id, rights, input ready);
    modport sink (input valid, kind, handle, object_type, object_id, rights, output ready);
endinterface

interface cte_rsp_if;
    import cte_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [TYPE_W-1:0]   out_object_type;
    logic [FIELD_W-1:0]  out_object_id;
    logic [COUNT_W-1:0]  revoked_count;
    logic [COUNT_W-1:0]  used_count;

    modport source (output valid, status, out_handle, out_object_type, out_object_id,
                    revoked_count, used_count, input ready);
    modport sink (input valid, status, out_handle, out_object_type, out_object_id,
                  revoked_count, used_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/capability_table_engine_core.sv */
// Operation: insert scans for a free slot; derive resolves the handle, then scans for a free
// slot; lookup resolves the handle, and delete resolves and clears it; revoke resolves the handle,
// repeats propagation passes over the table until a pass finds no change, then walks the
// table to delete each descendant and clears the target last.
// Throughput: one operation at a time; the sequencer and the single RAM read ports set it.
// Reset: asynchronous, active low; the table reads as empty at once, with no clearing pass.
`default_nettype none

module capability_table_engine_core #(
    parameter int SLOT_COUNT   = 256,
    parameter int INDEX_WIDTH  = 8,
    parameter int GEN_WIDTH    = 24,
    parameter int RIGHTS_WIDTH = 32,
    parameter int ID_WIDTH     = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cte_req_if.sink                    req,
    cte_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [cte_pkg::CFG_W-1:0]  cfg_wdata
);
    import cte_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int PW = INDEX_WIDTH + 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int DW = RIGHTS_WIDTH + TYPE_W + ID_WIDTH + PW;
    localparam logic [PW-1:0] NO_PARENT = '1;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);
    localparam logic [AW-1:0] FIRST = AW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_RES_RD, S_RES_CHK, S_FREE, S_FILL, S_FILL_HDL,
        S_CLR_RD, S_CLR_WR, S_SW_RD, S_SW_CHK, S_DEL, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [HANDLE_W-1:0]     hdl_reg;
    logic [RIGHTS_WIDTH-1:0] rights_reg;
    logic [TYPE_W-1:0]       stype_reg;
    logic [ID_WIDTH-1:0]     sid_reg;
    logic [PW-1:0]           parent_reg;
    logic [AW-1:0]           tgt_reg;
    logic [AW-1:0]           idx_reg;
    logic [AW-1:0]           free_reg;
    logic [CFG_W-1:0]        mask_reg;
    logic [CW-1:0]           cnt_reg;
    logic [SLOT_COUNT-1:0]   used_reg;
    logic [SLOT_COUNT-1:0]   gvld_reg;
    logic [SLOT_COUNT-1:0]   doomed_reg;
    logic                    changed_reg;
    logic                    sweep_reg;
    logic                    gv_rd_reg;
    logic [COUNT_W-1:0]      rc_reg;
    status_t                 res_status_reg;
    logic [HANDLE_W-1:0]     new_hdl_reg;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     o_status_reg;
    logic [HANDLE_W-1:0]     o_hdl_reg;
    logic [TYPE_W-1:0]       o_type_reg;
    logic [FIELD_W-1:0]      o_id_reg;
    logic [COUNT_W-1:0]      o_rc_reg;
    logic [COUNT_W-1:0]      o_uc_reg;

    logic                    gen_re;
    logic [AW-1:0]           gen_ra;
    logic [GEN_WIDTH-1:0]    gen_rdata;
    logic                    gen_we;
    logic [GEN_WIDTH-1:0]    gen_val;
    logic                    data_re;
    logic [AW-1:0]           data_ra;
    logic [DW-1:0]           data_rdata;
    logic                    data_we;
    logic [DW-1:0]           data_wdata;

    logic [INDEX_WIDTH-1:0]  hidx;
    logic                    resolved;
    logic [RIGHTS_WIDTH-1:0] d_rights;
    logic [TYPE_W-1:0]       d_type;
    logic [ID_WIDTH-1:0]     d_id;
    logic [PW-1:0]           d_parent;
    logic                    covers;
    logic                    hit;
    logic                    out_free;

    cte_ram #(.WIDTH(GEN_WIDTH), .DEPTH(SLOT_COUNT)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (idx_reg),
        .wdata (GEN_WIDTH'(gen_val + 1'b1)),
        .re    (gen_re),
        .raddr (gen_ra),
        .rdata (gen_rdata)
    );

    cte_ram #(.WIDTH(DW), .DEPTH(SLOT_COUNT)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (free_reg),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_ra),
        .rdata (data_rdata)
    );

    always_comb
    begin
        hidx = hdl_reg[INDEX_WIDTH-1:0];
        gen_val = gv_rd_reg ? gen_rdata : GEN_WIDTH'(1);
        {d_rights, d_type, d_id, d_parent} = data_rdata;
        resolved = (hidx != '0) && (32'(hidx) < 32'(SLOT_COUNT))
                   && used_reg[hidx[AW-1:0]]
                   && (32'(hdl_reg >> INDEX_WIDTH) == 32'(gen_val));
        covers = ((d_rights & rights_reg) == rights_reg);
        hit = used_reg[idx_reg] && !doomed_reg[idx_reg]
              && (32'(d_parent) < 32'(SLOT_COUNT)) && doomed_reg[d_parent[AW-1:0]];
        out_free = !rsp_valid_reg || rsp.ready;

        gen_re = 1'b0;
        gen_ra = idx_reg;
        data_re = 1'b0;
        data_ra = idx_reg;
        unique case (state_reg)
            S_RES_RD:
            begin
                gen_re = 1'b1;
                gen_ra = hidx[AW-1:0];
                data_re = 1'b1;
                data_ra = hidx[AW-1:0];
            end
            S_FILL:
            begin
                gen_re = 1'b1;
                gen_ra = free_reg;
            end
            S_CLR_RD:
            begin
                gen_re = 1'b1;
            end
            S_SW_RD:
            begin
                data_re = 1'b1;
            end
            default:
            begin
            end
        endcase
        gen_we = (state_reg == S_CLR_WR);
        data_we = (state_reg == S_FILL);
        data_wdata = {rights_reg, stype_reg, sid_reg, parent_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            hdl_reg        <= '0;
            rights_reg     <= '0;
            stype_reg      <= '0;
            sid_reg        <= '0;
            parent_reg     <= NO_PARENT;
            tgt_reg        <= '0;
            idx_reg        <= '0;
            free_reg       <= '0;
            mask_reg       <= REVOKE_MASK_RESET;
            cnt_reg        <= '0;
            used_reg       <= '0;
            gvld_reg       <= '0;
            doomed_reg     <= '0;
            changed_reg    <= 1'b0;
            sweep_reg      <= 1'b0;
            gv_rd_reg      <= 1'b0;
            rc_reg         <= '0;
            res_status_reg <= ST_OK;
            new_hdl_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            o_status_reg   <= '0;
            o_hdl_reg      <= '0;
            o_type_reg     <= '0;
            o_id_reg       <= '0;
            o_rc_reg       <= '0;
            o_uc_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            if (gen_re)
            begin
                gv_rd_reg <= gvld_reg[gen_ra];
            end
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg       <= req.kind;
                        hdl_reg        <= req.handle;
                        rights_reg     <= req.rights[RIGHTS_WIDTH-1:0];
                        stype_reg      <= req.object_type;
                        sid_reg        <= req.object_id[ID_WIDTH-1:0];
                        parent_reg     <= NO_PARENT;
                        rc_reg         <= '0;
                        new_hdl_reg    <= '0;
                        res_status_reg <= ST_OK;
                        idx_reg        <= FIRST;
                        case (req.kind) inside
                            KIND_INSERT:
                            begin
                                if (req.object_type == '0)
                                begin
                                    res_status_reg <= ST_BAD_OBJECT;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_FREE;
                                end
                            end
                            KIND_LOOKUP, KIND_DERIVE, KIND_DELETE, KIND_REVOKE:
                            begin
                                state_reg <= S_RES_RD;
                            end
                            default:
                            begin
                                res_status_reg <= ST_BAD_HANDLE;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RES_RD:
                begin
                    state_reg <= S_RES_CHK;
                end
                S_RES_CHK:
                begin
                    tgt_reg   <= hidx[AW-1:0];
                    idx_reg   <= FIRST;
                    stype_reg <= d_type;
                    sid_reg   <= d_id;
                    state_reg <= S_DONE;
                    if (!resolved)
                    begin
                        res_status_reg <= ST_BAD_HANDLE;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_LOOKUP:
                            begin
                                if (!covers)
                                begin
                                    res_status_reg <= ST_DENIED;
                                end
                            end
                            KIND_DERIVE:
                            begin
                                if (!covers)
                                begin
                                    res_status_reg <= ST_DENIED;
                                end
                                else
                                begin
                                    parent_reg <= PW'(hidx[AW-1:0]);
                                    state_reg  <= S_FREE;
                                end
                            end
                            KIND_DELETE:
                            begin
                                idx_reg   <= hidx[AW-1:0];
                                sweep_reg <= 1'b0;
                                state_reg <= S_CLR_RD;
                            end
                            default:
                            begin
                                if ((CFG_W'(d_rights) & mask_reg) == '0)
                                begin
                                    res_status_reg <= ST_DENIED;
                                end
                                else
                                begin
                                    doomed_reg  <= SLOT_COUNT'(1) << hidx[AW-1:0];
                                    changed_reg <= 1'b0;
                                    state_reg   <= S_SW_RD;
                                end
                            end
                        endcase
                    end
                end
                S_FREE:
                begin
                    if (!used_reg[idx_reg])
                    begin
                        free_reg  <= idx_reg;
                        state_reg <= S_FILL;
                    end
                    else if (idx_reg == LAST)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FILL:
                begin
                    used_reg[free_reg] <= 1'b1;
                    cnt_reg            <= cnt_reg + 1'b1;
                    state_reg          <= S_FILL_HDL;
                end
                S_FILL_HDL:
                begin
                    new_hdl_reg <= HANDLE_W'({gen_val, INDEX_WIDTH'(free_reg)});
                    state_reg   <= S_DONE;
                end
                S_CLR_RD:
                begin
                    state_reg <= S_CLR_WR;
                end
                S_CLR_WR:
                begin
                    gvld_reg[idx_reg] <= 1'b1;
                    used_reg[idx_reg] <= 1'b0;
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    if (!sweep_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg == LAST)
                    begin
                        idx_reg   <= tgt_reg;
                        sweep_reg <= 1'b0;
                        state_reg <= S_CLR_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DEL;
                    end
                end
                S_SW_RD:
                begin
                    state_reg <= S_SW_CHK;
                end
                S_SW_CHK:
                begin
                    if (hit)
                    begin
                        doomed_reg[idx_reg] <= 1'b1;
                    end
                    if (idx_reg == LAST)
                    begin
                        idx_reg     <= FIRST;
                        changed_reg <= 1'b0;
                        sweep_reg   <= 1'b1;
                        state_reg   <= (changed_reg || hit) ? S_SW_RD : S_DEL;
                    end
                    else
                    begin
                        changed_reg <= changed_reg || hit;
                        idx_reg     <= idx_reg + 1'b1;
                        state_reg   <= S_SW_RD;
                    end
                end
                S_DEL:
                begin
                    if (doomed_reg[idx_reg] && (idx_reg != tgt_reg))
                    begin
                        rc_reg    <= rc_reg + 1'b1;
                        state_reg <= S_CLR_RD;
                    end
                    else if (idx_reg == LAST)
                    begin
                        idx_reg   <= tgt_reg;
                        sweep_reg <= 1'b0;
                        state_reg <= S_CLR_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        o_status_reg  <= res_status_reg;
                        o_hdl_reg     <= new_hdl_reg;
                        o_rc_reg      <= rc_reg;
                        o_uc_reg      <= COUNT_W'(cnt_reg);
                        if ((kind_reg == KIND_LOOKUP) && (res_status_reg == ST_OK))
                        begin
                            o_type_reg <= stype_reg;
                            o_id_reg   <= FIELD_W'(sid_reg);
                        end
                        else
                        begin
                            o_type_reg <= '0;
                            o_id_reg   <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = o_status_reg;
    assign rsp.out_handle      = o_hdl_reg;
    assign rsp.out_object_type = o_type_reg;
    assign rsp.out_object_id   = o_id_reg;
    assign rsp.revoked_count   = o_rc_reg;
    assign rsp.used_count      = o_uc_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CW'($countones(used_reg)))
        else $error("Slot count disagrees with the used bits.");

    a_slot0_free: assert property (@(posedge clk) disable iff (!rst_n)
        !used_reg[0])
        else $error("Slot zero was handed out.");

    a_handle_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.out_handle != '0) |-> (rsp.out_handle[INDEX_WIDTH-1:0] != '0))
        else $error("A new handle carries index zero.");

    a_target_doomed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_CHK) |-> doomed_reg[tgt_reg])
        else $error("The revoke target is missing from the doomed set.");

endmodule

`default_nettype wire

/* hw/rtl/cte_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* tb/tb_capability_table_engine_core.sv */
// Self-checking testbench for capability_table_engine_core: directed and random
// table operations are scored against a table predictor kept in a scoreboard class.
// Depends on cte_pkg and on the cte_req_if and cte_rsp_if interfaces.
`default_nettype none

module tb_capability_table_engine_core;
    import cte_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] out_handle;
        logic [TYPE_W-1:0]   out_object_type;
        logic [FIELD_W-1:0]  out_object_id;
        logic [COUNT_W-1:0]  revoked_count;
        logic [COUNT_W-1:0]  used_count;
    } cap_result_t;

    class cap_table_scoreboard;
        bit          used[256];
        bit [23:0]   gen[256];
        bit [31:0]   rt[256];
        bit [2:0]    ty[256];
        bit [31:0]   oid[256];
        bit [8:0]    par[256];
        int unsigned in_use;
        bit [31:0]   revoke_mask;
        cap_result_t expected_q[$];
        int          errors;
        int          n_items;
        int          n_results;
        int          n_revoked;
        int          n_full;

        function new();
            for (int i = 0; i < 256; i++)
            begin
                used[i] = 0;
                gen[i] = 24'd1;
                rt[i] = 0;
                ty[i] = 0;
                oid[i] = 0;
                par[i] = 9'h1FF;
            end
            in_use = 0;
            revoke_mask = REVOKE_MASK_RESET;
            errors = 0;
            n_items = 0;
            n_results = 0;
            n_revoked = 0;
            n_full = 0;
        endfunction

        function int resolve(logic [31:0] h);
            int idx;
            idx = h[7:0];
            if (idx == 0 || !used[idx] || h[31:8] != gen[idx])
                return 0;
            return idx;
        endfunction

        function int first_free();
            for (int i = 1; i < 256; i++)
                if (!used[i])
                    return i;
            return 0;
        endfunction

        function logic [31:0] handle_of(int idx);
            return {gen[idx], idx[7:0]};
        endfunction

        function void occupy(int i, bit [2:0] t, bit [31:0] d, bit [31:0] r, bit [8:0] p);
            used[i] = 1;
            ty[i] = t;
            oid[i] = d;
            rt[i] = r;
            par[i] = p;
            in_use++;
        endfunction

        function void vacate(int i);
            used[i] = 0;
            ty[i] = 0;
            oid[i] = 0;
            rt[i] = 0;
            par[i] = 9'h1FF;
            gen[i] = gen[i] + 24'd1;
            if (in_use > 0)
                in_use--;
        endfunction

        function int sweep(int t);
            bit doomed[256];
            bit changed;
            int n;
            n = 0;
            for (int i = 0; i < 256; i++)
                doomed[i] = 0;
            doomed[t] = 1;
            changed = 1;
            while (changed)
            begin
                changed = 0;
                for (int i = 1; i < 256; i++)
                    if (used[i] && !doomed[i] && par[i] < 256 && doomed[par[i][7:0]])
                    begin
                        doomed[i] = 1;
                        changed = 1;
                    end
            end
            for (int i = 1; i < 256; i++)
                if (doomed[i] && i != t)
                begin
                    vacate(i);
                    n++;
                end
            return n;
        endfunction

        function logic [31:0] live_handle();
            int idx;
            for (int k = 0; k < 40; k++)
            begin
                idx = $urandom_range(255, 1);
                if (used[idx])
                    return handle_of(idx);
            end
            idx = first_free();
            for (int i = 1; i < 256; i++)
                if (used[i])
                    return handle_of(i);
            return $urandom;
        endfunction

        function void note_request(logic [2:0] kind, logic [31:0] h, logic [2:0] t,
                                   logic [31:0] d, logic [31:0] r);
            cap_result_t e;
            int s;
            int c;
            e.status = ST_OK;
            e.out_handle = 0;
            e.out_object_type = 0;
            e.out_object_id = 0;
            e.revoked_count = 0;
            n_items++;
            case (kind)
                KIND_INSERT:
                begin
                    c = first_free();
                    if (t == 0)
                        e.status = ST_BAD_OBJECT;
                    else if (c == 0)
                        e.status = ST_FULL;
                    else
                    begin
                        occupy(c, t, d, r, 9'h1FF);
                        e.out_handle = handle_of(c);
                    end
                end
                KIND_LOOKUP:
                begin
                    s = resolve(h);
                    if (s == 0)
                        e.status = ST_BAD_HANDLE;
                    else if ((rt[s] & r) != r)
                        e.status = ST_DENIED;
                    else
                    begin
                        e.out_object_type = ty[s];
                        e.out_object_id = oid[s];
                    end
                end
                KIND_DERIVE:
                begin
                    s = resolve(h);
                    c = first_free();
                    if (s == 0)
                        e.status = ST_BAD_HANDLE;
                    else if ((rt[s] & r) != r)
                        e.status = ST_DENIED;
                    else if (c == 0)
                        e.status = ST_FULL;
                    else
                    begin
                        occupy(c, ty[s], oid[s], r, s[8:0]);
                        e.out_handle = handle_of(c);
                    end
                end
                KIND_DELETE:
                begin
                    s = resolve(h);
                    if (s == 0)
                        e.status = ST_BAD_HANDLE;
                    else
                        vacate(s);
                end
                KIND_REVOKE:
                begin
                    s = resolve(h);
                    if (s == 0)
                        e.status = ST_BAD_HANDLE;
                    else if ((rt[s] & revoke_mask) == 0)
                        e.status = ST_DENIED;
                    else
                    begin
                        e.revoked_count = sweep(s);
                        vacate(s);
                        n_revoked++;
                    end
                end
                default:
                    e.status = ST_BAD_HANDLE;
            endcase
            if (e.status == ST_FULL)
                n_full++;
            e.used_count = in_use[7:0];
            expected_q.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch in transfer %0d: %s got 0x%0h expected 0x%0h",
                     n_results, what, got, want);
            errors++;
        endtask

        task check_result(cap_result_t g);
            cap_result_t e;
            n_results++;
            if (expected_q.size() == 0)
            begin
                report("unexpected response, status", g.status, 0);
                return;
            end
            e = expected_q.pop_front();
            if (g.status !== e.status)
                report("status", g.status, e.status);
            if (g.out_handle !== e.out_handle)
                report("out_handle", g.out_handle, e.out_handle);
            if (g.out_object_type !== e.out_object_type)
                report("out_object_type", g.out_object_type, e.out_object_type);
            if (g.out_object_id !== e.out_object_id)
                report("out_object_id", g.out_object_id, e.out_object_id);
            if (g.revoked_count !== e.revoked_count)
                report("revoked_count", g.revoked_count, e.revoked_count);
            if (g.used_count !== e.used_count)
                report("used_count", g.used_count, e.used_count);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          idle_pct;
    int          stall_pct;
    longint      cycles = 0;

    cte_req_if req ();
    cte_rsp_if rsp ();

    cap_table_scoreboard sb;

    capability_table_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cap_result_t g;
        cycles <= cycles + 1;
        if (cycles > 20000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[capability_table_engine_core] ERROR");
            $finish;
        end
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.kind, req.handle, req.object_type, req.object_id, req.rights);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            g.status = rsp.status;
            g.out_handle = rsp.out_handle;
            g.out_object_type = rsp.out_object_type;
            g.out_object_id = rsp.out_object_id;
            g.revoked_count = rsp.revoked_count;
            g.used_count = rsp.used_count;
            sb.check_result(g);
        end
    end

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    task send(logic [2:0] kind, logic [31:0] h, logic [2:0] t, logic [31:0] d,
              logic [31:0] r);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.handle <= h;
        req.object_type <= t;
        req.object_id <= d;
        req.rights <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task drain();
        req.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task write_mask(logic [31:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        sb.revoke_mask = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task random_item(bit fill_mode);
        int r;
        logic [31:0] h;
        logic [31:0] rights;
        r = $urandom_range(99);
        h = sb.live_handle();
        rights = $urandom;
        if (fill_mode)
            r = (r < 60) ? 0 : (r < 80) ? 25 : (r < 90) ? 45 : r;
        if (r < 20)
            send(KIND_INSERT, $urandom, 3'($urandom_range(7, 1)), $urandom, rights);
        else if (r < 40)
        begin
            if ($urandom_range(3) != 0)
                rights = sb.rt[h[7:0]] & $urandom;
            send(KIND_DERIVE, h, 3'($urandom), $urandom, rights);
        end
        else if (r < 60)
        begin
            if ($urandom_range(2) != 0)
                rights = sb.rt[h[7:0]] & $urandom;
            send(KIND_LOOKUP, h, 3'($urandom), $urandom, rights);
        end
        else if (r < 72)
            send(KIND_DELETE, h, 3'($urandom), $urandom, $urandom);
        else if (r < 87)
            send(KIND_REVOKE, h, 3'($urandom), $urandom, $urandom);
        else if (r < 91)
            send(3'($urandom_range(4)), $urandom, 3'($urandom), $urandom, $urandom);
        else if (r < 94)
            send(3'($urandom_range(7, 5)), h, 3'($urandom), $urandom, $urandom);
        else if (r < 97)
            send(3'($urandom_range(4, 1)), h ^ (32'h100 << $urandom_range(23)), 0, 0, 0);
        else
            send(KIND_INSERT, $urandom, 3'd0, $urandom, $urandom);
    endtask

    initial
    begin
        logic [31:0] ha;
        logic [31:0] hb;
        logic [31:0] hc;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 0;
        idle_pct = 0;
        stall_pct = 0;
        req.valid = 1'b0;
        req.kind = KIND_INSERT;
        req.handle = 0;
        req.object_type = 0;
        req.object_id = 0;
        req.rights = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(KIND_INSERT, 0, 3'd0, 32'h1234, 32'hFFFF_FFFF);
        send(KIND_INSERT, 0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_INSERT, 0, 3'd1, 32'h0, 32'hFFFF_FFFE);
        drain();
        ha = sb.handle_of(1);
        hb = sb.handle_of(2);
        send(KIND_LOOKUP, ha, 0, 0, 32'hFFFF_FFFF);
        send(KIND_LOOKUP, hb, 0, 0, 32'hFFFF_FFFF);
        send(KIND_LOOKUP, 32'h0, 0, 0, 0);
        send(KIND_LOOKUP, {24'd1, 8'd0}, 0, 0, 0);
        send(KIND_DERIVE, ha, 0, 0, 32'h0000_FFF1);
        send(KIND_DERIVE, hb, 0, 0, 32'hFFFF_FFFF);
        send(KIND_REVOKE, hb, 0, 0, 0);
        drain();
        hc = sb.handle_of(3);
        send(KIND_DERIVE, hc, 0, 0, 32'h0000_0011);
        send(KIND_DERIVE, ha, 0, 0, 32'h8000_0000);
        send(KIND_REVOKE, ha, 0, 0, 0);
        send(KIND_DELETE, ha, 0, 0, 0);
        send(KIND_LOOKUP, ha, 0, 0, 0);
        send(KIND_INSERT, 0, 3'd2, 32'hA5A5_5A5A, 32'h1);
        send(KIND_DERIVE, hb, 0, 0, 32'h0);
        drain();
        hc = sb.handle_of(1);
        send(KIND_DELETE, hb, 0, 0, 0);
        send(KIND_INSERT, 0, 3'd3, 32'h77, 32'h3);
        send(KIND_REVOKE, hc, 0, 0, 0);
        send(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        send(3'd5, 0, 0, 0, 0);
        send(3'd6, hc, 0, 0, 0);
        send(3'd7, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            case (ph)
                1: write_mask(32'h0);
                2: write_mask(32'hFFFF_FFFF);
                3: write_mask(32'h8000_0000);
                5: write_mask($urandom);
                6: write_mask(REVOKE_MASK_RESET);
                default: drain();
            endcase
            for (int k = 0; k < ((ph == 4) ? 260 : 60); k++)
                random_item(ph == 4);
        end

        drain();
        idle_pct = 0;
        stall_pct = 0;
        repeat (2000) @(posedge clk);
        $display("covered %0d requests and %0d responses: %0d successful revokes, %0d table-full",
                 sb.n_items, sb.n_results, sb.n_revoked, sb.n_full);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[capability_table_engine_core] OK");
        else
            $display("[capability_table_engine_core] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
